[sv/rrdt_pkg.sv]
package rrdt_pkg;

    typedef struct packed {
        logic [4:0] col;
        logic [4:0] row;
        logic [7:0] blob_byte;
    } texel_t;

    typedef struct packed {
        logic [12:0] byte_offset;
        logic [7:0]  intensity;
        logic [7:0]  displacement;
        logic        last;
    } result_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_ANGLE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FREQUENCY_Q8   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE_Q14  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DISP_GAIN      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEN_LOW      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEN_HIGH     = 3'd5;

    localparam logic [15:0] RST_PHASE_ANGLE   = 16'd0;
    localparam logic [15:0] RST_FREQUENCY_Q8  = 16'd15360;
    localparam logic [14:0] RST_AMPLITUDE_Q14 = 15'd13926;
    localparam logic [7:0]  RST_DISP_GAIN     = 8'd128;
    localparam logic [9:0]  RST_INTEN_LOW     = 10'd0;
    localparam logic [9:0]  RST_INTEN_HIGH    = 10'd400;

    localparam logic [20:0] SIN_C1 = 21'd1647099;
    localparam logic [20:0] SIN_C3 = 21'd677342;
    localparam logic [20:0] SIN_C5 = 21'd83564;
    localparam logic [12:0] SIN_C7 = 13'd4909;
    localparam logic [19:0] TWO_OVER_PI_Q20 = 20'd667544;

    localparam logic [18:0] DIV255_MUL = 19'd263173;
    localparam int unsigned DIV255_SHIFT = 26;

    localparam logic [7:0]  BLOB_ZERO_DISP = 8'd124;
    localparam logic [20:0] SIN_MAG_MAX = 21'd1048576;

    function automatic logic [12:0] texel_offset(input logic [5:0] x, input logic [5:0] y);
        texel_offset = {y[5:2], x[5:2], y[1:0], x[1:0], 1'b0};
    endfunction

endpackage

[sv/radial_ripple_displacement_texel.sv]
// Radial ripple texel generator. Each texel transaction (col, row, blob_byte) of the
// upper-left 32x32 quadrant yields four result transactions: the texel, its X mirror,
// its Y mirror and its XY mirror (last set), all with the same intensity and
// displacement bytes and their byte offsets in the 64x64 tiled texture. The single result
// port limits throughput: a new texel is taken once the last mirror result of the previous
// one is taken, or when none is held, and result_stall holds the flow. Texels pass a 27-stage
// arithmetic pipeline holding a 6-stage square root, the sine polynomial and a 9-stage
// divider, then the result register. Write configuration only while no transaction is in flight.
module radial_ripple_displacement_texel (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            texel_valid,
    output logic                            texel_stall,
    input  rrdt_pkg::texel_t                texel,
    output logic                            result_valid,
    input  logic                            result_stall,
    output rrdt_pkg::result_t               result,
    input  logic                            cfg_we,
    input  logic [rrdt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rrdt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int NST       = 27;
    localparam int SQ_FIRST  = 1;
    localparam int SQ_LAST   = 6;
    localparam int DIV_FIRST = 17;
    localparam int DIV_LAST  = 25;

    typedef struct packed {
        logic [4:0]  col;
        logic [4:0]  row;
        logic        blob_zero;
        logic [5:0]  ay;
        logic [11:0] q;
        logic [14:0] lev_num;
        logic [6:0]  lev;
        logic [17:0] inten_num;
        logic [7:0]  inten;
        logic [25:0] sq_rem;
        logic [23:0] root;
        logic [37:0] prod;
        logic [38:0] ph;
        logic [38:0] pl;
        logic [15:0] angle;
        logic        neg;
        logic [14:0] x;
        logic [14:0] x2;
        logic [20:0] p;
        logic [20:0] mag;
        logic [22:0] ag;
        logic [28:0] agy;
        logic [39:0] dvd;
        logic [17:0] quo;
        logic [7:0]  disp;
    } pipe_t;

    logic [15:0] phase_reg;
    logic [15:0] freq_reg;
    logic [14:0] amp_reg;
    logic [7:0]  gain_reg;
    logic [9:0]  low_reg;
    logic [9:0]  high_reg;

    pipe_t            pipe_reg [NST];
    pipe_t            pipe_next [NST];
    logic [NST-1:0]   vld_reg;
    logic             adv;

    logic [4:0]  tail_col_reg;
    logic [4:0]  tail_row_reg;
    logic [7:0]  tail_inten_reg;
    logic [7:0]  tail_disp_reg;
    logic        tail_vld_reg;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;

    logic [5:0]  out_x;
    logic [5:0]  out_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rrdt_pkg::RST_PHASE_ANGLE;
            freq_reg  <= rrdt_pkg::RST_FREQUENCY_Q8;
            amp_reg   <= rrdt_pkg::RST_AMPLITUDE_Q14;
            gain_reg  <= rrdt_pkg::RST_DISP_GAIN;
            low_reg   <= rrdt_pkg::RST_INTEN_LOW;
            high_reg  <= rrdt_pkg::RST_INTEN_HIGH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rrdt_pkg::REG_PHASE_ANGLE:   phase_reg <= cfg_data;
                rrdt_pkg::REG_FREQUENCY_Q8:  freq_reg  <= cfg_data;
                rrdt_pkg::REG_AMPLITUDE_Q14: amp_reg   <= cfg_data[14:0];
                rrdt_pkg::REG_DISP_GAIN:     gain_reg  <= cfg_data[7:0];
                rrdt_pkg::REG_INTEN_LOW:     low_reg   <= cfg_data[9:0];
                rrdt_pkg::REG_INTEN_HIGH:    high_reg  <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    assign adv         = !tail_vld_reg || (!result_stall && (cnt_reg == 2'd3));
    assign texel_stall = !adv;

    always_comb
    begin
        logic [5:0]  ax;
        logic [5:0]  ay;
        logic [25:0] r;
        logic [25:0] t;
        logic [15:0] qx;
        logic [1:0]  pr;
        logic [39:0] sh;
        logic [57:0] wsum;
        logic [33:0] m34;
        logic [36:0] m37;
        logic [28:0] m29;
        logic [27:0] m28;
        logic [35:0] m36;
        logic [49:0] m50;
        logic [15:0] dpos;
        logic [9:0]  inten10;
        int          idx;
        int          si;

        ax = 6'd32 - {1'b0, texel.col};
        ay = 6'd32 - {1'b0, texel.row};
        pipe_next[0]           = pipe_reg[0];
        pipe_next[0].col       = texel.col;
        pipe_next[0].row       = texel.row;
        pipe_next[0].blob_zero = (texel.blob_byte == 8'd0);
        pipe_next[0].ay        = ay;
        pipe_next[0].q         = 12'(12'(ax) * 12'(ax)) + 12'(12'(ay) * 12'(ay));
        pipe_next[0].lev_num   = 15'(15'(texel.blob_byte) * 15'd127);
        pipe_next[0].sq_rem    = '0;
        pipe_next[0].root      = '0;

        for (int k = 1; k < NST; k++)
        begin
            pipe_next[k] = pipe_reg[k-1];

            if (k == 1)
            begin
                m34 = 34'(pipe_reg[k-1].lev_num) * 34'(rrdt_pkg::DIV255_MUL);
                pipe_next[k].lev = m34[rrdt_pkg::DIV255_SHIFT +: 7];
            end
            if (k == 2)
            begin
                pipe_next[k].inten_num =
                    18'(18'(low_reg) * 18'(8'd255 - {1'b0, pipe_reg[k-1].lev}))
                    + 18'(18'(high_reg) * 18'(pipe_reg[k-1].lev));
            end
            if (k == 3)
            begin
                m37 = 37'(pipe_reg[k-1].inten_num) * 37'(rrdt_pkg::DIV255_MUL);
                inten10 = m37[rrdt_pkg::DIV255_SHIFT +: 10];
                pipe_next[k].inten = (inten10 > 10'd255) ? 8'd255 : inten10[7:0];
            end

            if (k >= SQ_FIRST && k <= SQ_LAST)
            begin
                qx = {4'b0, pipe_reg[k-1].q};
                for (int j = 0; j < 4; j++)
                begin
                    idx = 23 - 4 * (k - SQ_FIRST) - j;
                    pr  = (idx >= 16) ? qx[2*idx-31 -: 2] : 2'b00;
                    r   = {pipe_next[k].sq_rem[23:0], pr};
                    t   = {pipe_next[k].root, 2'b01};
                    if (r >= t)
                    begin
                        pipe_next[k].sq_rem = r - t;
                        pipe_next[k].root   = {pipe_next[k].root[22:0], 1'b1};
                    end
                    else
                    begin
                        pipe_next[k].sq_rem = r;
                        pipe_next[k].root   = {pipe_next[k].root[22:0], 1'b0};
                    end
                end
            end

            if (k == 7)
                pipe_next[k].prod = 38'(pipe_reg[k-1].root[21:0]) * 38'(freq_reg);
            if (k == 8)
            begin
                pipe_next[k].ph = 39'(pipe_reg[k-1].prod[37:19]) * 39'(rrdt_pkg::TWO_OVER_PI_Q20);
                pipe_next[k].pl = 39'(pipe_reg[k-1].prod[18:0]) * 39'(rrdt_pkg::TWO_OVER_PI_Q20);
            end
            if (k == 9)
            begin
                wsum = {pipe_reg[k-1].ph, 19'b0} + 58'(pipe_reg[k-1].pl);
                pipe_next[k].angle = phase_reg + wsum[51:36];
            end
            if (k == 10)
            begin
                pipe_next[k].neg = pipe_reg[k-1].angle[15];
                pipe_next[k].x   = pipe_reg[k-1].angle[14]
                                 ? 15'd16384 - {1'b0, pipe_reg[k-1].angle[13:0]}
                                 : {1'b0, pipe_reg[k-1].angle[13:0]};
                m29 = 29'(pipe_next[k].x) * 29'(pipe_next[k].x);
                pipe_next[k].x2 = m29[28:14];
            end
            if (k == 11)
            begin
                m28 = 28'(pipe_reg[k-1].x2) * 28'(rrdt_pkg::SIN_C7);
                pipe_next[k].p = rrdt_pkg::SIN_C5 - 21'(m28[27:14]);
            end
            if (k == 12)
            begin
                m36 = 36'(pipe_reg[k-1].x2) * 36'(pipe_reg[k-1].p);
                pipe_next[k].p = rrdt_pkg::SIN_C3 - m36[34:14];
            end
            if (k == 13)
            begin
                m36 = 36'(pipe_reg[k-1].x2) * 36'(pipe_reg[k-1].p);
                pipe_next[k].p = rrdt_pkg::SIN_C1 - m36[34:14];
            end
            if (k == 14)
            begin
                m36 = 36'(pipe_reg[k-1].x) * 36'(pipe_reg[k-1].p);
                pipe_next[k].mag = (m36[35:14] > 22'(rrdt_pkg::SIN_MAG_MAX))
                                 ? rrdt_pkg::SIN_MAG_MAX : m36[34:14];
                pipe_next[k].ag  = 23'(amp_reg) * 23'(gain_reg);
            end
            if (k == 15)
                pipe_next[k].agy = 29'(pipe_reg[k-1].ag) * 29'(pipe_reg[k-1].ay);
            if (k == 16)
            begin
                m50 = 50'(pipe_reg[k-1].agy) * 50'(pipe_reg[k-1].mag);
                pipe_next[k].dvd = m50[49:10];
                pipe_next[k].quo = '0;
            end

            if (k >= DIV_FIRST && k <= DIV_LAST)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    si = 17 - 2 * (k - DIV_FIRST) - j;
                    sh = 40'(pipe_reg[k-1].root[21:0]) << si;
                    if (pipe_next[k].dvd >= sh)
                    begin
                        pipe_next[k].dvd     = pipe_next[k].dvd - sh;
                        pipe_next[k].quo[si] = 1'b1;
                    end
                end
            end

            if (k == NST - 1)
            begin
                dpos = 16'd32768 - {1'b0, pipe_reg[k-1].quo[14:0]};
                if (pipe_reg[k-1].blob_zero)
                    pipe_next[k].disp = rrdt_pkg::BLOB_ZERO_DISP;
                else if (pipe_reg[k-1].neg)
                    pipe_next[k].disp = (pipe_reg[k-1].quo[17:15] != 3'd0)
                                      ? 8'd255 : {1'b1, pipe_reg[k-1].quo[14:8]};
                else
                    pipe_next[k].disp = (pipe_reg[k-1].quo[17:15] != 3'd0)
                                      ? 8'd0 : dpos[15:8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], texel_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NST; k++)
                pipe_reg[k] <= pipe_next[k];
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (adv)
            cnt_next = 2'd0;
        else if (tail_vld_reg && !result_stall)
            cnt_next = cnt_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_vld_reg <= 1'b0;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (adv)
                tail_vld_reg <= vld_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tail_col_reg   <= pipe_reg[NST-1].col;
            tail_row_reg   <= pipe_reg[NST-1].row;
            tail_inten_reg <= pipe_reg[NST-1].inten;
            tail_disp_reg  <= pipe_reg[NST-1].disp;
        end
    end

    assign out_x = cnt_reg[0] ? {1'b1, ~tail_col_reg} : {1'b0, tail_col_reg};
    assign out_y = cnt_reg[1] ? {1'b1, ~tail_row_reg} : {1'b0, tail_row_reg};

    assign result_valid        = tail_vld_reg;
    assign result.byte_offset  = rrdt_pkg::texel_offset(out_x, out_y);
    assign result.intensity    = tail_inten_reg;
    assign result.displacement = tail_disp_reg;
    assign result.last         = (cnt_reg == 2'd3);

    a_mirror_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result.last |=> result_valid)
        else $error("mirror result missing after non-last result");

    a_bytes_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result.last
        |=> $stable(result.intensity) && $stable(result.displacement))
        else $error("texel bytes changed between mirror results");

    a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        texel_stall |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_texel_enters: assert property (@(posedge clk) disable iff (!rst_n)
        texel_valid && !texel_stall |=> vld_reg[0])
        else $error("accepted texel not captured");

endmodule

[tb/sv/radial_ripple_displacement_texel_test.sv]
`timescale 1ns / 1ps

module radial_ripple_displacement_texel_test;

    localparam logic [rrdt_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    logic clk;
    logic rst_n;
    logic texel_valid;
    logic texel_stall;
    rrdt_pkg::texel_t texel;
    logic result_valid;
    logic result_stall;
    rrdt_pkg::result_t result;
    logic cfg_we;
    logic [rrdt_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [rrdt_pkg::CFG_DATA_W-1:0] cfg_data;

    radial_ripple_displacement_texel dut (
        .clk(clk), .rst_n(rst_n),
        .texel_valid(texel_valid), .texel_stall(texel_stall), .texel(texel),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    logic [15:0] phase_angle;
    logic [15:0] frequency_q8;
    logic [14:0] amplitude_q14;
    logic [7:0]  displacement_gain;
    logic [9:0]  inten_low;
    logic [9:0]  inten_high;

    rrdt_pkg::result_t pending_results[$];
    int errors;
    bit quiet;
    int hold_off;
    int stall_left;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] rem;
        res = 0;
        rem = v;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [12:0] tiled_offset(input logic [5:0] x, input logic [5:0] y);
        logic [31:0] yo;
        logic [31:0] xo;
        yo = ((32'(y) & 32'd3) << 2) | ((32'(y) & ~32'd3) << 6);
        xo = (32'(x) & 32'd3) | ((32'(x) & ~32'd3) << 2);
        return 13'(((yo | xo) << 1) & 32'h1FFF);
    endfunction

    function automatic logic [7:0] ripple_displacement(input rrdt_pkg::texel_t t);
        logic [63:0] ax, ay, q, s16, term, x, x2, p, mag, num, t8;
        logic [15:0] angle;
        logic [1:0] quad;
        longint d;
        if (t.blob_byte == 8'd0)
            return rrdt_pkg::BLOB_ZERO_DISP;
        ax = 64'd32 - 64'(t.col);
        ay = 64'd32 - 64'(t.row);
        q = ax * ax + ay * ay;
        s16 = isqrt64(q << 32);
        term = (s16 * 64'(frequency_q8) * 64'd667544) >> 36;
        angle = 16'(64'(phase_angle) + term);
        quad = angle[15:14];
        x = 64'(angle[13:0]);
        if (quad[0])
            x = 64'd16384 - x;
        x2 = (x * x) >> 14;
        p = 64'd83564 - ((x2 * 64'd4909) >> 14);
        p = 64'd677342 - ((x2 * p) >> 14);
        p = 64'd1647099 - ((x2 * p) >> 14);
        mag = (x * p) >> 14;
        if (mag > (64'd1 << 20))
            mag = 64'd1 << 20;
        num = 64'(amplitude_q14) * 64'(displacement_gain) * ay * mag;
        t8 = num / (s16 << 10);
        if (quad[1])
            d = 32768 + longint'(t8);
        else
            d = 32768 - longint'(t8);
        if (d < 0)
            return 8'd0;
        if ((d >>> 8) > 255)
            return 8'd255;
        return 8'(d >>> 8);
    endfunction

    task automatic predict_mirrors(input rrdt_pkg::texel_t t);
        logic [31:0] level, inten;
        logic [7:0] disp;
        logic [5:0] xs[4], ys[4];
        rrdt_pkg::result_t r;
        level = 32'(t.blob_byte) * 32'd127 / 32'd255;
        inten = (32'(inten_low) * (32'd255 - level) + 32'(inten_high) * level) / 32'd255;
        if (inten > 32'd255)
            inten = 32'd255;
        disp = ripple_displacement(t);
        xs[0] = 6'(t.col);         ys[0] = 6'(t.row);
        xs[1] = 6'(63 - t.col);    ys[1] = 6'(t.row);
        xs[2] = 6'(t.col);         ys[2] = 6'(63 - t.row);
        xs[3] = 6'(63 - t.col);    ys[3] = 6'(63 - t.row);
        for (int k = 0; k < 4; k++)
        begin
            r.byte_offset = tiled_offset(xs[k], ys[k]);
            r.intensity = inten[7:0];
            r.displacement = disp;
            r.last = (k == 3);
            pending_results.push_back(r);
        end
    endtask

    task automatic send_texel(input logic [4:0] c, input logic [4:0] r, input logic [7:0] b);
        int gap;
        if (!quiet && $urandom_range(3) == 0)
        begin
            gap = $urandom_range(7, 1);
            texel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        texel_valid <= 1'b1;
        texel <= '{col: c, row: r, blob_byte: b};
        @(posedge clk);
        while (texel_stall)
            @(posedge clk);
        predict_mirrors('{col: c, row: r, blob_byte: b});
    endtask

    task automatic write_reg(input logic [rrdt_pkg::CFG_INDEX_W-1:0] idx,
        input logic [rrdt_pkg::CFG_DATA_W-1:0] val);
        texel_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            rrdt_pkg::REG_PHASE_ANGLE:   phase_angle = val;
            rrdt_pkg::REG_FREQUENCY_Q8:  frequency_q8 = val;
            rrdt_pkg::REG_AMPLITUDE_Q14: amplitude_q14 = val[14:0];
            rrdt_pkg::REG_DISP_GAIN:     displacement_gain = val[7:0];
            rrdt_pkg::REG_INTEN_LOW:     inten_low = val[9:0];
            rrdt_pkg::REG_INTEN_HIGH:    inten_high = val[9:0];
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin
        rrdt_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction %h", result);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.byte_offset !== want.byte_offset)
                begin
                    $error("byte_offset expected %0d actual %0d", want.byte_offset,
                        result.byte_offset);
                    errors++;
                end
                if (result.intensity !== want.intensity)
                begin
                    $error("intensity expected %0d actual %0d", want.intensity,
                        result.intensity);
                    errors++;
                end
                if (result.displacement !== want.displacement)
                begin
                    $error("displacement expected %0d actual %0d", want.displacement,
                        result.displacement);
                    errors++;
                end
                if (result.last !== want.last)
                begin
                    $error("last expected %0d actual %0d", want.last, result.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            result_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end
        else if (quiet)
            result_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(5) == 0)
        begin
            result_stall <= 1'b1;
            stall_left <= int'($urandom_range(6, 0));
        end
        else
            result_stall <= 1'b0;
    end

    task automatic test_directed_extremes();
        send_texel(5'd0, 5'd0, 8'd0);
        send_texel(5'd31, 5'd31, 8'd255);
        send_texel(5'd0, 5'd31, 8'd1);
        send_texel(5'd31, 5'd0, 8'd128);
        send_texel(5'd21, 5'd10, 8'd2);
        send_texel(5'd10, 5'd21, 8'd254);
        send_texel(5'd16, 5'd16, 8'd0);
    endtask

    task automatic write_phase_and_send(input logic [15:0] ph, input logic [4:0] c,
        input logic [4:0] r, input logic [7:0] b);
        write_reg(rrdt_pkg::REG_PHASE_ANGLE, ph);
        send_texel(c, r, b);
    endtask

    task automatic test_saturation();
        write_reg(rrdt_pkg::REG_AMPLITUDE_Q14, 16'h7FFF);
        write_reg(rrdt_pkg::REG_DISP_GAIN, 16'hFFFF);
        write_reg(rrdt_pkg::REG_INTEN_LOW, 16'h03FF);
        write_reg(rrdt_pkg::REG_INTEN_HIGH, 16'h03FF);
        for (int i = 0; i < 10; i++)
            write_phase_and_send(16'(i * 6553), 5'(i * 3), 5'(31 - i), 8'(i * 28 + 1));
    endtask

    task automatic test_zero_settings();
        write_reg(rrdt_pkg::REG_FREQUENCY_Q8, 16'd0);
        write_reg(rrdt_pkg::REG_AMPLITUDE_Q14, 16'd0);
        write_reg(rrdt_pkg::REG_DISP_GAIN, 16'd0);
        write_reg(rrdt_pkg::REG_INTEN_LOW, 16'd0);
        write_reg(rrdt_pkg::REG_INTEN_HIGH, 16'd0);
        write_reg(rrdt_pkg::REG_PHASE_ANGLE, 16'hFFFF);
        send_texel(5'd5, 5'd7, 8'd200);
        send_texel(5'd31, 5'd31, 8'd255);
        write_reg(REG_UNUSED, 16'h1234);
        write_reg(rrdt_pkg::REG_FREQUENCY_Q8, 16'hFFFF);
        send_texel(5'd0, 5'd0, 8'd255);
        send_texel(5'd12, 5'd3, 8'd90);
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 4; phase++)
        begin
            write_reg(rrdt_pkg::REG_PHASE_ANGLE, 16'($urandom));
            write_reg(rrdt_pkg::REG_FREQUENCY_Q8, 16'($urandom));
            write_reg(rrdt_pkg::REG_AMPLITUDE_Q14, 16'($urandom));
            write_reg(rrdt_pkg::REG_DISP_GAIN, 16'($urandom));
            write_reg(rrdt_pkg::REG_INTEN_LOW, 16'($urandom));
            write_reg(rrdt_pkg::REG_INTEN_HIGH, 16'($urandom));
            for (int i = 0; i < 15; i++)
                send_texel(5'($urandom), 5'($urandom),
                    ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom));
        end
    endtask

    task automatic test_backpressure();
        write_reg(rrdt_pkg::REG_FREQUENCY_Q8, rrdt_pkg::RST_FREQUENCY_Q8);
        write_reg(rrdt_pkg::REG_AMPLITUDE_Q14, 16'(rrdt_pkg::RST_AMPLITUDE_Q14));
        write_reg(rrdt_pkg::REG_DISP_GAIN, 16'(rrdt_pkg::RST_DISP_GAIN));
        write_reg(rrdt_pkg::REG_INTEN_HIGH, 16'(rrdt_pkg::RST_INTEN_HIGH));
        @(posedge clk);
        hold_off <= 200;
        for (int i = 0; i < 30; i++)
            send_texel(5'($urandom), 5'($urandom), 8'($urandom));
        while (hold_off > 0)
            @(posedge clk);
    endtask

    task automatic test_streaming();
        quiet = 1'b1;
        for (int i = 0; i < 20; i++)
            send_texel(5'($urandom), 5'($urandom), 8'($urandom));
    endtask

    initial
    begin
        int drain;
        clk = 1'b0;
        errors = 0;
        quiet = 1'b0;
        hold_off = 0;
        stall_left = 0;
        rst_n = 1'b0;
        texel_valid = 1'b0;
        texel = '0;
        result_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        phase_angle = rrdt_pkg::RST_PHASE_ANGLE;
        frequency_q8 = rrdt_pkg::RST_FREQUENCY_Q8;
        amplitude_q14 = rrdt_pkg::RST_AMPLITUDE_Q14;
        displacement_gain = rrdt_pkg::RST_DISP_GAIN;
        inten_low = rrdt_pkg::RST_INTEN_LOW;
        inten_high = rrdt_pkg::RST_INTEN_HIGH;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_saturation();
        test_zero_settings();
        test_random_settings();
        test_backpressure();
        test_streaming();
        texel_valid <= 1'b0;
        drain = 0;
        while (pending_results.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (40) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
